FILE: rtl/cbt_pkg.sv
package cbt_pkg;

    typedef enum logic
    {
        OP_LOAD,
        OP_STEP
    } op_t;

    // Control point store is split in three banks by point index modulo 3
    typedef enum logic [1:0]
    {
        BANK_A,
        BANK_B,
        BANK_C
    } bank_t;

    typedef struct packed
    {
        op_t   op;
        bank_t bank;
        logic  pass_start;
        logic  last;
    } cbt_ctrl_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int WEIGHT_W    = 17;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_W     = 5;
    localparam int SEG_OUT_W   = 3;
    localparam int STEP_OUT_W  = 7;

endpackage

FILE: rtl/cbt_front.sv
module cbt_front #(
    parameter int NUM_SEGMENTS      = 8,
    parameter int STEPS_PER_SEGMENT = 100,
    parameter int RW                = 3,
    parameter int SW                = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         full,
    input  logic                         cmd,
    input  logic [cbt_pkg::INDEX_W-1:0]  point_index,
    output logic                         push,
    output cbt_pkg::cbt_ctrl_t           ctrl,
    output logic [RW-1:0]                row,
    output logic [SW-1:0]                step_idx
);
    import cbt_pkg::*;

    localparam int NPTS = 3 * NUM_SEGMENTS;

    logic [RW-1:0]        seg_reg, seg_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 accept;
    logic                 is_step;
    logic                 in_range;
    logic [8:0]           idx_x11;
    logic [3:0]           quot;
    logic [4:0]           remd;
    logic [RW+3:0]        quot_ext;

    assign accept  = start && !full;
    assign is_step = (cmd == 1'b1);

    // Divide the 5-bit index by 3 through a reciprocal multiply (exact for 0..31)
    assign idx_x11  = 9'(point_index) * 9'd11;
    assign quot     = idx_x11[8:5];
    assign remd     = point_index - 5'({quot, 1'b0}) - 5'(quot);
    assign quot_ext = {{RW{1'b0}}, quot};
    assign in_range = int'(point_index) < NPTS;

    // Drop loads that address no slot
    assign push = accept && (is_step || in_range);

    always_comb
    begin
        ctrl.op         = is_step ? OP_STEP : OP_LOAD;
        ctrl.bank       = bank_t'(remd[1:0]);
        ctrl.pass_start = (seg_reg == '0) && (step_reg == '0);
        ctrl.last       = (seg_reg == RW'(NUM_SEGMENTS - 1)) &&
                          (step_reg == SW'(STEPS_PER_SEGMENT - 1));
        row             = is_step ? seg_reg : quot_ext[RW-1:0];
        step_idx        = step_reg;
    end

    always_comb
    begin
        seg_next  = seg_reg;
        step_next = step_reg;
        if (accept && is_step)
        begin
            if (step_reg == SW'(STEPS_PER_SEGMENT - 1))
            begin
                step_next = '0;
                if (seg_reg == RW'(NUM_SEGMENTS - 1))
                begin
                    seg_next = '0;
                end
                else
                begin
                    seg_next = seg_reg + RW'(1);
                end
            end
            else
            begin
                step_next = step_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            seg_reg  <= seg_next;
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/cbt_queue.sv
module cbt_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);
    import cbt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/cbt_back.sv
module cbt_back #(
    parameter int NUM_SEGMENTS      = 8,
    parameter int STEPS_PER_SEGMENT = 100,
    parameter int COORD_WIDTH       = 20,
    parameter int RW                = 3,
    parameter int SW                = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  cbt_pkg::cbt_ctrl_t                   ctrl,
    input  logic [RW-1:0]                        row,
    input  logic [SW-1:0]                        step_idx,
    input  logic [COORD_WIDTH-1:0]               ld_x,
    input  logic [COORD_WIDTH-1:0]               ld_y,
    input  logic [COORD_WIDTH-1:0]               ld_z,
    output logic                                 done,
    output logic signed [COORD_WIDTH-1:0]        out_x,
    output logic signed [COORD_WIDTH-1:0]        out_y,
    output logic signed [COORD_WIDTH-1:0]        out_z,
    output logic [cbt_pkg::SEG_OUT_W-1:0]        segment_number,
    output logic [cbt_pkg::STEP_OUT_W-1:0]       step_number,
    output logic                                 end_of_loop,
    output logic                                 new_highest,
    output logic signed [COORD_WIDTH-1:0]        highest_y,
    output logic [cbt_pkg::SEG_OUT_W-1:0]        highest_segment,
    output logic [cbt_pkg::STEP_OUT_W-1:0]       highest_step
);
    import cbt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PTW = 3 * CW;
    localparam int PRW = CW + WEIGHT_W + 1;
    localparam int SMW = CW + 4;
    localparam longint S3 = longint'(STEPS_PER_SEGMENT) * longint'(STEPS_PER_SEGMENT) *
                            longint'(STEPS_PER_SEGMENT);

    function automatic logic [WEIGHT_W-1:0] weight_of(input int j, input int k);
        longint kk;
        longint u;
        longint num;
        kk = longint'(k);
        u  = longint'(STEPS_PER_SEGMENT) - kk;
        case (j)
            0:       num = u * u * u;
            1:       num = 3 * kk * u * u;
            2:       num = 3 * kk * kk * u;
            default: num = kk * kk * kk;
        endcase
        return WEIGHT_W'((num * 65536 + S3 / 2) / S3);
    endfunction

    logic [WEIGHT_W-1:0] wrom [STEPS_PER_SEGMENT][4];

    for (genvar gk = 0; gk < STEPS_PER_SEGMENT; gk++)
    begin : g_rom_k
        for (genvar gj = 0; gj < 4; gj++)
        begin : g_rom_j
            assign wrom[gk][gj] = weight_of(gj, gk);
        end
    end

    // Control point banks: A holds points 3r, B 3r+1, C 3r+2
    logic [PTW-1:0] bank_a [NUM_SEGMENTS];
    logic [PTW-1:0] bank_b [NUM_SEGMENTS];
    logic [PTW-1:0] bank_c [NUM_SEGMENTS];
    logic signed [CW-1:0] start_y_reg;

    logic                 is_load, is_step;
    logic [RW-1:0]        row_end;

    // Stage 1: store read and weight lookup
    logic                 valid_s1;
    logic [PTW-1:0]       pt_s1 [4];
    logic [WEIGHT_W-1:0]  w_s1 [4];
    logic [RW-1:0]        seg_s1;
    logic [SW-1:0]        step_s1;
    logic                 pass_s1, last_s1;
    logic signed [CW-1:0] sy_s1;

    // Stage 2: products
    logic                 valid_s2;
    logic signed [PRW-1:0] prod_next [3][4];
    logic signed [PRW-1:0] prod_s2 [3][4];
    logic [RW-1:0]        seg_s2;
    logic [SW-1:0]        step_s2;
    logic                 pass_s2, last_s2;
    logic signed [CW-1:0] sy_s2;

    // Stage 3: sum and saturate
    logic                 valid_s3;
    logic signed [SMW-1:0] sum_c [3];
    logic signed [CW-1:0] sat_c [3];
    logic signed [CW-1:0] pt_s3 [3];
    logic [RW-1:0]        seg_s3;
    logic [SW-1:0]        step_s3;
    logic                 pass_s3, last_s3;
    logic signed [CW-1:0] sy_s3;

    localparam logic signed [SMW-1:0] SAT_MAX = {5'b00000, {(CW-1){1'b1}}};
    localparam logic signed [SMW-1:0] SAT_MIN = {5'b11111, {(CW-1){1'b0}}};

    // Stage 4: highest point tracking and result
    logic signed [CW-1:0] base_y;
    logic                 newh;
    logic signed [CW-1:0] hy_next;
    logic [RW-1:0]        hseg_next;
    logic [SW-1:0]        hstep_next;

    logic                 done_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [RW-1:0]        seg_out_reg;
    logic [SW-1:0]        step_out_reg;
    logic                 eol_reg, newh_reg;
    logic signed [CW-1:0] hy_reg;
    logic [RW-1:0]        hseg_reg;
    logic [SW-1:0]        hstep_reg;
    logic [RW+2:0]        seg_ext, hseg_ext;
    logic [SW+6:0]        step_ext, hstep_ext;

    assign is_load = in_valid && (ctrl.op == OP_LOAD);
    assign is_step = in_valid && (ctrl.op == OP_STEP);
    // Last segment closes the loop on point 0
    assign row_end = (row == RW'(NUM_SEGMENTS - 1)) ? '0 : row + RW'(1);

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            if (ctrl.bank == BANK_A)
            begin
                bank_a[row] <= {ld_x, ld_y, ld_z};
                if (row == RW'(NUM_SEGMENTS - 1))
                begin
                    start_y_reg <= ld_y;
                end
            end
            else if (ctrl.bank == BANK_B)
            begin
                bank_b[row] <= {ld_x, ld_y, ld_z};
            end
            else
            begin
                bank_c[row] <= {ld_x, ld_y, ld_z};
            end
        end
        pt_s1[0] <= bank_a[row];
        pt_s1[1] <= bank_b[row];
        pt_s1[2] <= bank_c[row];
        pt_s1[3] <= bank_a[row_end];
        for (int j = 0; j < 4; j++)
        begin
            w_s1[j] <= wrom[step_idx][j];
        end
        seg_s1  <= row;
        step_s1 <= step_idx;
        pass_s1 <= ctrl.pass_start;
        last_s1 <= ctrl.last;
        sy_s1   <= start_y_reg;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[c][j] = $signed(pt_s1[j][(2-c)*CW +: CW]) *
                                  $signed({1'b0, w_s1[j]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_s2 <= prod_next;
        seg_s2  <= seg_s1;
        step_s2 <= step_s1;
        pass_s2 <= pass_s1;
        last_s2 <= last_s1;
        sy_s2   <= sy_s1;
    end

    // Floor shift of each product, then sum and clamp
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_c[c] = '0;
            for (int j = 0; j < 4; j++)
            begin
                sum_c[c] = sum_c[c] + {{2{prod_s2[c][j][PRW-1]}},
                                       prod_s2[c][j][PRW-1:FRAC_BITS]};
            end
            if (sum_c[c] > SAT_MAX)
            begin
                sat_c[c] = SAT_MAX[CW-1:0];
            end
            else if (sum_c[c] < SAT_MIN)
            begin
                sat_c[c] = SAT_MIN[CW-1:0];
            end
            else
            begin
                sat_c[c] = sum_c[c][CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pt_s3   <= sat_c;
        seg_s3  <= seg_s2;
        step_s3 <= step_s2;
        pass_s3 <= pass_s2;
        last_s3 <= last_s2;
        sy_s3   <= sy_s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1 <= 1'b0;
            valid_s2 <= 1'b0;
            valid_s3 <= 1'b0;
        end
        else
        begin
            valid_s1 <= is_step;
            valid_s2 <= valid_s1;
            valid_s3 <= valid_s2;
        end
    end

    // A pass restarts the running maximum from the last segment's start anchor
    always_comb
    begin
        base_y     = pass_s3 ? sy_s3 : hy_reg;
        newh       = pt_s3[1] > base_y;
        hy_next    = newh ? pt_s3[1] : base_y;
        hseg_next  = newh ? seg_s3 : (pass_s3 ? '0 : hseg_reg);
        hstep_next = newh ? step_s3 : (pass_s3 ? '0 : hstep_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            hy_reg    <= '0;
            hseg_reg  <= '0;
            hstep_reg <= '0;
        end
        else
        begin
            done_reg <= valid_s3;
            if (valid_s3)
            begin
                hy_reg    <= hy_next;
                hseg_reg  <= hseg_next;
                hstep_reg <= hstep_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_s3)
        begin
            out_x_reg    <= pt_s3[0];
            out_y_reg    <= pt_s3[1];
            out_z_reg    <= pt_s3[2];
            seg_out_reg  <= seg_s3;
            step_out_reg <= step_s3;
            eol_reg      <= last_s3;
            newh_reg     <= newh;
        end
    end

    assign seg_ext   = {3'b000, seg_out_reg};
    assign hseg_ext  = {3'b000, hseg_reg};
    assign step_ext  = {7'b0000000, step_out_reg};
    assign hstep_ext = {7'b0000000, hstep_reg};

    assign done            = done_reg;
    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;
    assign out_z           = out_z_reg;
    assign segment_number  = seg_ext[SEG_OUT_W-1:0];
    assign step_number     = step_ext[STEP_OUT_W-1:0];
    assign end_of_loop     = eol_reg;
    assign new_highest     = newh_reg;
    assign highest_y       = hy_reg;
    assign highest_segment = hseg_ext[SEG_OUT_W-1:0];
    assign highest_step    = hstep_ext[STEP_OUT_W-1:0];

endmodule

FILE: rtl/cubic_bezier_loop_tessellator.sv
// A step item passes through the queue and then the store read, multiply, sum and
// compare registers before its point shows with done high; a load item gives no result.
// Throughput: one item per cycle; the back end runs a fixed four-stage pipeline
// (store read, multiply, sum, compare) and never stalls, so busy stays low.
// Reset clears the counters, the running highest point, the queue and the pipeline;
// the control point store is not cleared and needs no clearing pass.
module cubic_bezier_loop_tessellator #(
    parameter int NUM_SEGMENTS      = 8,
    parameter int STEPS_PER_SEGMENT = 100,
    parameter int COORD_WIDTH       = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cmd,
    input  logic [cbt_pkg::INDEX_W-1:0]          point_index,
    input  logic signed [COORD_WIDTH-1:0]        in_x,
    input  logic signed [COORD_WIDTH-1:0]        in_y,
    input  logic signed [COORD_WIDTH-1:0]        in_z,
    output logic                                 done,
    output logic signed [COORD_WIDTH-1:0]        out_x,
    output logic signed [COORD_WIDTH-1:0]        out_y,
    output logic signed [COORD_WIDTH-1:0]        out_z,
    output logic [cbt_pkg::SEG_OUT_W-1:0]        segment_number,
    output logic [cbt_pkg::STEP_OUT_W-1:0]       step_number,
    output logic                                 end_of_loop,
    output logic                                 new_highest,
    output logic signed [COORD_WIDTH-1:0]        highest_y,
    output logic [cbt_pkg::SEG_OUT_W-1:0]        highest_segment,
    output logic [cbt_pkg::STEP_OUT_W-1:0]       highest_step
);
    import cbt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int RW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int SW = $clog2(STEPS_PER_SEGMENT);
    localparam int CTW = $bits(cbt_ctrl_t);
    localparam int QW = CTW + RW + SW + 3 * CW;

    logic               push;
    logic               full;
    cbt_ctrl_t          f_ctrl;
    logic [RW-1:0]      f_row;
    logic [SW-1:0]      f_step;
    logic [QW-1:0]      q_in, q_out;
    logic               q_valid;
    cbt_ctrl_t          b_ctrl;
    logic [RW-1:0]      b_row;
    logic [SW-1:0]      b_step;
    logic [CW-1:0]      b_x, b_y, b_z;

    assign busy = full;

    cbt_front #(
        .NUM_SEGMENTS      (NUM_SEGMENTS),
        .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT),
        .RW                (RW),
        .SW                (SW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .full        (full),
        .cmd         (cmd),
        .point_index (point_index),
        .push        (push),
        .ctrl        (f_ctrl),
        .row         (f_row),
        .step_idx    (f_step)
    );

    assign q_in = {f_ctrl, f_row, f_step, in_x, in_y, in_z};

    cbt_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (full),
        .pop       (q_valid),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    assign b_ctrl = cbt_ctrl_t'(q_out[QW-1 -: CTW]);
    assign b_row  = q_out[3*CW+SW +: RW];
    assign b_step = q_out[3*CW +: SW];
    assign b_x    = q_out[2*CW +: CW];
    assign b_y    = q_out[CW +: CW];
    assign b_z    = q_out[0 +: CW];

    cbt_back #(
        .NUM_SEGMENTS      (NUM_SEGMENTS),
        .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT),
        .COORD_WIDTH       (COORD_WIDTH),
        .RW                (RW),
        .SW                (SW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (q_valid),
        .ctrl            (b_ctrl),
        .row             (b_row),
        .step_idx        (b_step),
        .ld_x            (b_x),
        .ld_y            (b_y),
        .ld_z            (b_z),
        .done            (done),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .segment_number  (segment_number),
        .step_number     (step_number),
        .end_of_loop     (end_of_loop),
        .new_highest     (new_highest),
        .highest_y       (highest_y),
        .highest_segment (highest_segment),
        .highest_step    (highest_step)
    );

endmodule

FILE: dv/tb_cubic_bezier_loop_tessellator.sv
module tb_cubic_bezier_loop_tessellator;

    import cbt_pkg::*;

    localparam int NUM_SEGMENTS      = 8;
    localparam int STEPS_PER_SEGMENT = 100;
    localparam int COORD_W           = 20;
    localparam int NUM_PTS           = 3 * NUM_SEGMENTS;
    localparam int START_PT          = 3 * (NUM_SEGMENTS - 1);
    localparam longint COORD_MAX     = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;
    localparam int RANDOM_ITEMS      = 1100;
    localparam int TAIL_CYCLES       = 12;

    typedef struct
    {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [SEG_OUT_W-1:0]      seg;
        logic [STEP_OUT_W-1:0]     stp;
        logic                      eol;
        logic                      newh;
        logic signed [COORD_W-1:0] hi_y;
        logic [SEG_OUT_W-1:0]      hi_seg;
        logic [STEP_OUT_W-1:0]     hi_stp;
    } curve_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cmd = 1'b0;
    logic [INDEX_W-1:0] point_index = '0;
    logic signed [COORD_W-1:0] in_x = '0;
    logic signed [COORD_W-1:0] in_y = '0;
    logic signed [COORD_W-1:0] in_z = '0;
    logic busy;
    logic done;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [SEG_OUT_W-1:0] segment_number;
    logic [STEP_OUT_W-1:0] step_number;
    logic end_of_loop;
    logic new_highest;
    logic signed [COORD_W-1:0] highest_y;
    logic [SEG_OUT_W-1:0] highest_segment;
    logic [STEP_OUT_W-1:0] highest_step;

    // tessellator state as the testbench tracks it
    logic signed [COORD_W-1:0] ctrl_pt [NUM_PTS][3];
    int seg_cnt = 0;
    int step_cnt = 0;
    longint top_y = 0;
    int top_seg = 0;
    int top_step = 0;

    curve_point_t expected_points[$];
    int mismatch_count = 0;
    bit gaps_on = 1'b1;

    cubic_bezier_loop_tessellator #(
        .NUM_SEGMENTS(NUM_SEGMENTS),
        .STEPS_PER_SEGMENT(STEPS_PER_SEGMENT),
        .COORD_WIDTH(COORD_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .point_index(point_index),
        .in_x(in_x),
        .in_y(in_y),
        .in_z(in_z),
        .done(done),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .segment_number(segment_number),
        .step_number(step_number),
        .end_of_loop(end_of_loop),
        .new_highest(new_highest),
        .highest_y(highest_y),
        .highest_segment(highest_segment),
        .highest_step(highest_step)
    );

    always #6 clk = ~clk;

    function automatic longint bernstein_weight(input int j, input int k);
        longint s;
        longint u;
        longint s3;
        longint num;
        begin
            s = STEPS_PER_SEGMENT;
            u = s - k;
            s3 = s * s * s;
            case (j)
                0: num = u * u * u;
                1: num = 3 * k * u * u;
                2: num = 3 * k * k * u;
                default: num = longint'(k) * k * k;
            endcase
            return (num * 65536 + s3 / 2) / s3;
        end
    endfunction

    function automatic longint coord_clamp(input longint v);
        begin
            if (v > COORD_MAX)
                return COORD_MAX;
            if (v < COORD_MIN)
                return COORD_MIN;
            return v;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        begin
            case ($urandom_range(0, 3))
                0: return COORD_W'(COORD_MAX);
                1: return COORD_W'(COORD_MIN);
                default: return COORD_W'($urandom);
            endcase
        end
    endfunction

    task automatic trace_curve_point(output curve_point_t res);
        int slot [4];
        longint w [4];
        longint acc;
        longint pt [3];
        begin
            // a fresh pass restarts the running maximum from the loop's last anchor
            if (seg_cnt == 0 && step_cnt == 0)
            begin
                top_y = ctrl_pt[START_PT][1];
                top_seg = 0;
                top_step = 0;
            end
            for (int j = 0; j < 4; j++)
            begin
                slot[j] = (3 * seg_cnt + j >= NUM_PTS) ? 0 : 3 * seg_cnt + j;
                w[j] = bernstein_weight(j, step_cnt);
            end
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int j = 0; j < 4; j++)
                    acc += (longint'(ctrl_pt[slot[j]][c]) * w[j]) >>> 16;
                pt[c] = coord_clamp(acc);
            end
            res.newh = (pt[1] > top_y);
            if (res.newh)
            begin
                top_y = pt[1];
                top_seg = seg_cnt;
                top_step = step_cnt;
            end
            res.x = COORD_W'(pt[0]);
            res.y = COORD_W'(pt[1]);
            res.z = COORD_W'(pt[2]);
            res.seg = SEG_OUT_W'(seg_cnt);
            res.stp = STEP_OUT_W'(step_cnt);
            res.eol = (seg_cnt == NUM_SEGMENTS - 1) && (step_cnt == STEPS_PER_SEGMENT - 1);
            res.hi_y = COORD_W'(top_y);
            res.hi_seg = SEG_OUT_W'(top_seg);
            res.hi_stp = STEP_OUT_W'(top_step);
            if (step_cnt + 1 >= STEPS_PER_SEGMENT)
            begin
                step_cnt = 0;
                seg_cnt = (seg_cnt + 1 >= NUM_SEGMENTS) ? 0 : seg_cnt + 1;
            end
            else
            begin
                step_cnt++;
            end
        end
    endtask

    task automatic send_item(input op_t op, input logic [INDEX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
        curve_point_t res;
        begin
            while (gaps_on && $urandom_range(0, 99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            cmd <= op;
            point_index <= idx;
            in_x <= x;
            in_y <= y;
            in_z <= z;
            do
                @(posedge clk);
            while (busy);
            if (op == OP_STEP)
            begin
                trace_curve_point(res);
                expected_points.insert(expected_points.size(), res);
            end
            else if (idx < NUM_PTS)
            begin
                ctrl_pt[idx][0] = x;
                ctrl_pt[idx][1] = y;
                ctrl_pt[idx][2] = z;
            end
        end
    endtask

    task automatic wait_for_results();
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (expected_points.size() != 0);
        end
    endtask

    task automatic count_mismatch(input string msg);
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        begin
            if (got !== want)
                count_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    always @(posedge clk)
    begin
        curve_point_t want;
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                count_mismatch("curve point with none expected");
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("out_x", want.x, out_x);
                check_field("out_y", want.y, out_y);
                check_field("out_z", want.z, out_z);
                check_field("segment_number", want.seg, segment_number);
                check_field("step_number", want.stp, step_number);
                check_field("end_of_loop", want.eol, end_of_loop);
                check_field("new_highest", want.newh, new_highest);
                check_field("highest_y", want.hi_y, highest_y);
                check_field("highest_segment", want.hi_seg, highest_segment);
                check_field("highest_step", want.hi_stp, highest_step);
            end
        end
    end

    // fill every slot, mostly with extreme coordinates; the first segment sits at the rails
    // so that weights rounding above one push the sum into saturation
    task automatic test_extreme_loads();
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        begin
            for (int i = 0; i < NUM_PTS; i++)
            begin
                px = i[0] ? COORD_W'(COORD_MIN) : COORD_W'(COORD_MAX);
                py = i[1] ? COORD_W'(COORD_MIN) : COORD_W'(COORD_MAX);
                pz = i[2] ? COORD_W'(COORD_MAX) : '0;
                if (i < 4)
                begin
                    px = COORD_W'(COORD_MAX);
                    py = COORD_W'(COORD_MIN);
                    pz = COORD_W'(COORD_MIN);
                end
                if (i == START_PT)
                    py = 20'sd3000;
                send_item(OP_LOAD, INDEX_W'(i), px, py, pz);
            end
        end
    endtask

    // loads past the end of the store must leave it alone
    task automatic test_ignored_loads();
        begin
            send_item(OP_LOAD, INDEX_W'(NUM_PTS), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX),
                      COORD_W'(COORD_MAX));
            send_item(OP_LOAD, '1, COORD_W'(COORD_MIN), COORD_W'(COORD_MAX),
                      COORD_W'(COORD_MIN));
        end
    endtask

    // first steps of a pass, then hold until every point is back
    task automatic test_pass_start();
        begin
            for (int i = 0; i < 4; i++)
                send_item(OP_STEP, INDEX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
            wait_for_results();
        end
    endtask

    task automatic test_random_traffic();
        op_t op;
        begin
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                gaps_on = !(n >= 400 && n < 700);
                if (n == 850)
                    wait_for_results();
                op = ($urandom_range(0, 99) < 88) ? OP_STEP : OP_LOAD;
                send_item(op, INDEX_W'($urandom_range(0, 31)), rand_coord(), rand_coord(),
                          rand_coord());
            end
            gaps_on = 1'b1;
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_PTS; i++)
            for (int c = 0; c < 3; c++)
                ctrl_pt[i][c] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_loads();
        test_ignored_loads();
        test_pass_start();
        test_random_traffic();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
